/* hw/rtl/twrb_pkg.sv */
`timescale 1ns / 1ps

package twrb_pkg;

    // half-period register and its reset value
    localparam int HALF_W = 16;
    localparam logic [HALF_W-1:0] HALF_PERIOD_RST = 16'd4;

    // frame position counter in half-periods, 7 bits wide
    localparam int STEP_W     = 7;
    localparam int TAIL_HALVES = 3;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN    = 1'd1;

    // pin and status levels of one cycle, sclk in the lowest bit
    typedef struct packed {
        logic done;
        logic busy;
        logic locked;
        logic shdn_n;
        logic sdata_oe;
        logic sdata_out;
        logic csn;
        logic sclk;
    } t_pins;

    localparam int PINS_W = $bits(t_pins);

endpackage

/* hw/rtl/twrb_core.sv */
`timescale 1ns / 1ps

module twrb_core import twrb_pkg::*; #(
    parameter int ADDR_BITS         = 12,
    parameter int DATA_BITS         = 32,
    parameter int TURNAROUND_CLOCKS = 3,
    parameter int DIVIDER_BITS      = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_start_req,
    input  logic                 i_op,
    input  logic [ADDR_BITS-1:0] i_address,
    input  logic [DATA_BITS-1:0] i_write_data,
    input  logic                 i_sdata_in,
    input  logic                 i_lock_detect_in,
    input  logic [HALF_W-1:0]    i_half_period,
    input  logic                 i_shutdown,
    output t_pins                o_pins,
    output logic [DATA_BITS-1:0] o_read_data
);

    localparam int CLOCKS_PER_FRAME = ADDR_BITS + 1 + TURNAROUND_CLOCKS + DATA_BITS;
    localparam int CMP_W = (DIVIDER_BITS > HALF_W) ? DIVIDER_BITS : HALF_W;
    localparam logic [STEP_W-1:0] FRAME_HALVES = STEP_W'(2 * CLOCKS_PER_FRAME);
    localparam logic [STEP_W-1:0] FRAME_END    = STEP_W'(2 * CLOCKS_PER_FRAME + TAIL_HALVES);
    localparam logic [STEP_W-1:0] ADDR_CLKS    = STEP_W'(ADDR_BITS);
    localparam logic [STEP_W-1:0] DATA_FIRST   = STEP_W'(ADDR_BITS + 1 + TURNAROUND_CLOCKS);

    logic                    r_active, n_active;
    logic                    r_read, n_read;
    logic [STEP_W-1:0]       r_step, n_step;
    logic [DIVIDER_BITS-1:0] r_div, n_div;
    logic [ADDR_BITS-1:0]    r_addr, n_addr;
    logic [DATA_BITS-1:0]    r_data, n_data;

    logic [DIVIDER_BITS-1:0] div_inc;
    logic [HALF_W-1:0]       half_eff;
    logic                    half_end;
    logic [STEP_W-1:0]       clk_idx;
    logic [STEP_W-1:0]       n_clk_idx;
    logic                    done;
    logic [DATA_BITS-1:0]    rdata;

    // divider: a zero half-period setting behaves as a setting of one
    assign div_inc  = r_div + 1'b1;
    assign half_eff = (i_half_period == '0) ? HALF_W'(1) : i_half_period;
    assign half_end = (CMP_W'(div_inc) >= CMP_W'(half_eff)) || (div_inc == '0);
    assign clk_idx  = {1'b0, r_step[STEP_W-1:1]};

    always_comb begin
        n_active = r_active;
        n_read   = r_read;
        n_step   = r_step;
        n_div    = r_div;
        n_addr   = r_addr;
        n_data   = r_data;
        done     = 1'b0;
        rdata    = '0;
        if (r_active) begin
            if (half_end) begin
                n_div = '0;
                if (r_step < FRAME_HALVES) begin
                    if (!r_step[0]) begin
                        // end of low phase: sample read data
                        if (r_read && clk_idx >= DATA_FIRST) begin
                            n_data = (r_data << 1) | DATA_BITS'(i_sdata_in);
                        end
                    end else begin
                        // end of high phase: next bit to the top
                        if (clk_idx < ADDR_CLKS) begin
                            n_addr = r_addr << 1;
                        end else if (!r_read && clk_idx >= DATA_FIRST) begin
                            n_data = r_data << 1;
                        end
                    end
                end
                n_step = r_step + 1'b1;
                if (n_step >= FRAME_END) begin
                    n_active = 1'b0;
                    n_step   = '0;
                    done     = 1'b1;
                    rdata    = r_read ? n_data : '0;
                end
            end else begin
                n_div = div_inc;
            end
        end else if (i_start_req) begin
            n_active = 1'b1;
            n_step   = '0;
            n_div    = '0;
            n_read   = i_op;
            n_addr   = i_address;
            n_data   = i_op ? '0 : i_write_data;
        end
    end

    // pin levels follow the updated state
    assign n_clk_idx = {1'b0, n_step[STEP_W-1:1]};

    always_comb begin
        o_pins           = '0;
        o_pins.csn       = 1'b1;
        o_pins.shdn_n    = !i_shutdown;
        o_pins.locked    = i_lock_detect_in;
        o_pins.busy      = n_active;
        o_pins.done      = done;
        if (n_active && n_step < FRAME_HALVES) begin
            o_pins.csn  = 1'b0;
            o_pins.sclk = n_step[0];
            if (n_clk_idx < ADDR_CLKS) begin
                o_pins.sdata_oe  = 1'b1;
                o_pins.sdata_out = n_addr[ADDR_BITS-1];
            end else if (n_clk_idx == ADDR_CLKS) begin
                o_pins.sdata_oe  = 1'b1;
                o_pins.sdata_out = n_read;
            end else if (!n_read) begin
                o_pins.sdata_oe = 1'b1;
                if (n_clk_idx >= DATA_FIRST) begin
                    o_pins.sdata_out = n_data[DATA_BITS-1];
                end
            end
        end
    end

    assign o_read_data = rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_read   <= 1'b0;
            r_step   <= '0;
            r_div    <= '0;
        end else if (i_step) begin
            r_active <= n_active;
            r_read   <= n_read;
            r_step   <= n_step;
            r_div    <= n_div;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_addr <= n_addr;
            r_data <= n_data;
        end
    end

endmodule

/* hw/rtl/twrb_out_reg.sv */
`timescale 1ns / 1ps

module twrb_out_reg import twrb_pkg::*; #(
    parameter int DATA_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  t_pins                i_pins,
    input  logic [DATA_BITS-1:0] i_read_data,
    input  logic                 i_ready,
    output logic                 o_valid,
    output t_pins                o_pins,
    output logic [DATA_BITS-1:0] o_read_data,
    output logic                 o_load_ok
);

    logic                 r_valid;
    t_pins                r_pins;
    logic [DATA_BITS-1:0] r_read_data;

    // free when empty or when the held result leaves this cycle
    assign o_load_ok = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pins      <= i_pins;
            r_read_data <= i_read_data;
        end
    end

    assign o_valid     = r_valid;
    assign o_pins      = r_pins;
    assign o_read_data = r_read_data;

endmodule

/* hw/rtl/three_wire_register_bus_master_top.sv */
// Result request: registered, valid in the cycle after its input request is accepted.
// Throughput: one request per cycle while results are taken; the result register
//   frees itself in the cycle its contents are taken, so input tready stays high under flow.
// Reset (synchronous, active low): bus idle, csn high, half-period 4,
//   shutdown off, result register empty. No clearing pass.
`timescale 1ns / 1ps

module three_wire_register_bus_master_top import twrb_pkg::*; #(
    parameter int ADDR_BITS         = 12,
    parameter int DATA_BITS         = 32,
    parameter int TURNAROUND_CLOCKS = 3,
    parameter int DIVIDER_BITS      = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input requests, one per system clock of bus time
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // start_req, op, address, write_data, sdata_in, lock_detect_in
    input  logic [((4 + ADDR_BITS + DATA_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // result requests, one per input request
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // sclk, csn, sdata_out, sdata_oe, shdn_n, locked, busy_res, done_res,
    // read_data
    output logic [((PINS_W + DATA_BITS + 7) / 8) * 8 - 1:0] o_m_axis_tdata,
    // register writes
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [HALF_W-1:0]      i_cfg_data
);

    localparam int OUT_W       = PINS_W + DATA_BITS;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // input field offsets
    localparam int OFS_ADDR  = 2;
    localparam int OFS_WDATA = OFS_ADDR + ADDR_BITS;
    localparam int OFS_SDI   = OFS_WDATA + DATA_BITS;
    localparam int OFS_LD    = OFS_SDI + 1;

    logic [HALF_W-1:0]    r_half_period;
    logic                 r_shutdown;

    logic                 in_fire;
    logic                 load_ok;
    t_pins                core_pins;
    logic [DATA_BITS-1:0] core_rdata;
    t_pins                out_pins;
    logic [DATA_BITS-1:0] out_rdata;

    // config registers; the user writes them only while the bus is quiet, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
            r_shutdown    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_HALF_PERIOD: r_half_period <= i_cfg_data;
                CFG_SHUTDOWN:    r_shutdown    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = load_ok;
    assign in_fire         = i_s_axis_tvalid && load_ok;

    // frame sequencer: divider, half-period counter, shifters, pin decode
    twrb_core #(
        .ADDR_BITS         (ADDR_BITS),
        .DATA_BITS         (DATA_BITS),
        .TURNAROUND_CLOCKS (TURNAROUND_CLOCKS),
        .DIVIDER_BITS      (DIVIDER_BITS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (in_fire),
        .i_start_req      (i_s_axis_tdata[0]),
        .i_op             (i_s_axis_tdata[1]),
        .i_address        (i_s_axis_tdata[OFS_WDATA-1:OFS_ADDR]),
        .i_write_data     (i_s_axis_tdata[OFS_SDI-1:OFS_WDATA]),
        .i_sdata_in       (i_s_axis_tdata[OFS_SDI]),
        .i_lock_detect_in (i_s_axis_tdata[OFS_LD]),
        .i_half_period    (r_half_period),
        .i_shutdown       (r_shutdown),
        .o_pins           (core_pins),
        .o_read_data      (core_rdata)
    );

    // result register, decouples the two sides
    twrb_out_reg #(
        .DATA_BITS (DATA_BITS)
    ) u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_fire),
        .i_pins      (core_pins),
        .i_read_data (core_rdata),
        .i_ready     (i_m_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .o_pins      (out_pins),
        .o_read_data (out_rdata),
        .o_load_ok   (load_ok)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'({out_rdata, out_pins});

    // done marks the end of a transaction, so busy is already low
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && out_pins.done) |-> !out_pins.busy)
        else $error("done with busy still high");

    // idle bus leaves chip select high and the line released
    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !out_pins.busy) |->
            (out_pins.csn && !out_pins.sclk && !out_pins.sdata_oe))
        else $error("bus pins active while idle");

    // every accepted request produces a result request
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> o_m_axis_tvalid)
        else $error("accepted request without result");

    // a held result that is not taken blocks the input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while result register full");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import twrb_pkg::*;

    // bus geometry at the block's default parameters
    localparam int N_ADDR       = 12;
    localparam int N_DATA       = 32;
    localparam int N_TURN       = 3;
    localparam int DATA_FIRST   = N_ADDR + 1 + N_TURN;       // first data clock
    localparam int FRAME_HALVES = 2 * (DATA_FIRST + N_DATA); // 96 half-periods
    localparam int OUT_W        = 40;  // 40 bits of fields, already whole bytes
    localparam int STALL_LIMIT  = 2000;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } t_bus_op;

    // level driven on the shared data line during a read
    typedef enum int {
        LINE_LOW,
        LINE_HIGH,
        LINE_RANDOM
    } t_line_mode;

    // one input request, start_req in bit 0; 48 bits, already whole bytes
    typedef struct packed {
        logic              lock;
        logic              sdata;
        logic [N_DATA-1:0] wdata;
        logic [N_ADDR-1:0] addr;
        t_bus_op           op;
        logic              start;
    } t_bus_request;

    // one result request, sclk in bit 0
    typedef struct packed {
        logic [N_DATA-1:0] read_data;
        t_pins             pins;
    } t_bus_result;

    // Predicts pin levels cycle by cycle and holds them until the block's
    // result request for the same cycle comes back.
    class pin_scoreboard;
        logic [HALF_W-1:0] half_cfg;
        logic              shutdown_cfg;
        logic [STEP_W-1:0] half_step;
        logic [15:0]       div_cnt;
        logic [N_ADDR-1:0] addr_sr;
        logic [N_DATA-1:0] data_sr;
        logic              read_op;
        logic              busy;
        t_bus_result       expected_results[$];
        int                failures;

        function new();
            half_cfg     = HALF_PERIOD_RST;
            shutdown_cfg = 1'b0;
            half_step    = '0;
            div_cnt      = '0;
            addr_sr      = '0;
            data_sr      = '0;
            read_op      = 1'b0;
            busy         = 1'b0;
            failures     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [HALF_W-1:0] value);
            if (idx == CFG_HALF_PERIOD)
                half_cfg = value;
            else if (idx == CFG_SHUTDOWN)
                shutdown_cfg = value[0];
        endfunction

        // shift registers move at the end of each half-period
        function void close_half(logic sdata);
            int c;
            c = int'(half_step) >> 1;
            if (int'(half_step) < FRAME_HALVES) begin
                if (!half_step[0]) begin
                    if (read_op && c >= DATA_FIRST)
                        data_sr = {data_sr[N_DATA-2:0], sdata};
                end else begin
                    if (c < N_ADDR)
                        addr_sr = addr_sr << 1;
                    else if (!read_op && c >= DATA_FIRST)
                        data_sr = data_sr << 1;
                end
            end
            half_step = half_step + 1'b1;
        endfunction

        function void note_request(t_bus_request r);
            t_bus_result       res;
            logic [15:0]       half_eff;
            logic [15:0]       next_cnt;
            int                c;
            res           = '0;
            res.pins.csn  = 1'b1;
            if (busy) begin
                half_eff = (half_cfg == '0) ? 16'd1 : half_cfg;
                next_cnt = div_cnt + 16'd1;
                if (next_cnt >= half_eff || next_cnt == 16'd0) begin
                    div_cnt = '0;
                    close_half(r.sdata);
                    if (int'(half_step) >= FRAME_HALVES + TAIL_HALVES) begin
                        busy          = 1'b0;
                        half_step     = '0;
                        res.pins.done = 1'b1;
                        res.read_data = read_op ? data_sr : '0;
                    end
                end else begin
                    div_cnt = next_cnt;
                end
            end else if (r.start) begin
                busy      = 1'b1;
                half_step = '0;
                div_cnt   = '0;
                read_op   = (r.op == OP_READ);
                addr_sr   = r.addr;
                data_sr   = (r.op == OP_READ) ? '0 : r.wdata;
            end

            if (busy && int'(half_step) < FRAME_HALVES) begin
                c             = int'(half_step) >> 1;
                res.pins.csn  = 1'b0;
                res.pins.sclk = half_step[0];
                if (c < N_ADDR) begin
                    res.pins.sdata_oe  = 1'b1;
                    res.pins.sdata_out = addr_sr[N_ADDR-1];
                end else if (c == N_ADDR) begin
                    res.pins.sdata_oe  = 1'b1;
                    res.pins.sdata_out = read_op;
                end else if (!read_op) begin
                    // write turnaround drives low, then the data bits
                    res.pins.sdata_oe = 1'b1;
                    if (c >= DATA_FIRST)
                        res.pins.sdata_out = data_sr[N_DATA-1];
                end
            end
            res.pins.shdn_n = !shutdown_cfg;
            res.pins.locked = r.lock;
            res.pins.busy   = busy;
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [N_DATA-1:0] exp_v,
                                    logic [N_DATA-1:0] act_v);
            if (exp_v !== act_v) begin
                failures++;
                if (failures <= 30)
                    $display("%0t mismatch on %s: expected %0h, actual %0h",
                             $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(t_bus_result act);
            t_bus_result e;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= 30)
                    $display("%0t result with nothing expected: %0h", $time, act);
                return;
            end
            e = expected_results.pop_front();
            compare_field("sclk", e.pins.sclk, act.pins.sclk);
            compare_field("csn", e.pins.csn, act.pins.csn);
            compare_field("sdata_out", e.pins.sdata_out, act.pins.sdata_out);
            compare_field("sdata_oe", e.pins.sdata_oe, act.pins.sdata_oe);
            compare_field("shdn_n", e.pins.shdn_n, act.pins.shdn_n);
            compare_field("locked", e.pins.locked, act.pins.locked);
            compare_field("busy", e.pins.busy, act.pins.busy);
            compare_field("done", e.pins.done, act.pins.done);
            compare_field("read_data", e.read_data, act.read_data);
        endfunction
    endclass

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_valid  = 1'b0;
    logic              s_ready;
    t_bus_request      s_data   = '0;
    logic              m_valid;
    logic              m_ready  = 1'b0;
    logic [OUT_W-1:0]  m_data;
    logic              cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = CFG_HALF_PERIOD;
    logic [HALF_W-1:0] cfg_data = '0;

    // idling on either side; both are switched off for the last phase
    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    int quiet_cycles = 0;

    pin_scoreboard sb;

    three_wire_register_bus_master_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        // start_req, op, address, write_data, sdata_in, lock_detect_in
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // sclk, csn, sdata_out, sdata_oe, shdn_n, locked, busy_res, done_res,
        // read_data
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: values read straight after the edge are the ones the
    // block saw at that edge, since everything changes by nonblocking update.
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready)
            sb.check_result(t_bus_result'(m_data));
    end

    // Watchdog: no request moving on either side for too long ends the run.
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver back-pressure in bursts of random length.
    initial begin
        forever begin
            if (stalls_on && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    function automatic logic line_level(t_line_mode mode);
        case (mode)
            LINE_LOW:  return 1'b0;
            LINE_HIGH: return 1'b1;
            default:   return 1'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic logic [N_ADDR-1:0] pick_addr();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return N_ADDR'($urandom);
        endcase
    endfunction

    function automatic logic [N_DATA-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // One input request: optional gap, then hold tvalid until taken.
    task automatic send_request(input t_bus_request r);
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge i_clk); while (!s_ready);
        sb.note_request(r);
    endtask

    // A whole frame from its start request to done. With keep_start the
    // start bit stays high throughout, so it is offered while busy and on
    // the done cycle itself, where it must be ignored.
    task automatic run_frame(input t_bus_op op, input logic [N_ADDR-1:0] addr,
                             input logic [N_DATA-1:0] wdata, input t_line_mode line,
                             input bit keep_start);
        t_bus_request r;
        r       = '0;
        r.start = 1'b1;
        r.op    = op;
        r.addr  = addr;
        r.wdata = wdata;
        r.sdata = line_level(line);
        r.lock  = 1'($urandom_range(0, 1));
        send_request(r);
        while (sb.busy) begin
            r.start = keep_start;
            r.op    = t_bus_op'($urandom_range(0, 1));
            r.addr  = N_ADDR'($urandom);
            r.wdata = $urandom;
            r.sdata = line_level(line);
            r.lock  = 1'($urandom_range(0, 1));
            send_request(r);
        end
    endtask

    // Mostly back-to-back frames with random contents; the odd stray start
    // while busy and the odd idle cycle between frames.
    task automatic run_random(input int n, input bit may_end_busy);
        t_bus_request r;
        for (int i = 0; i < n; i++) begin
            r       = '0;
            r.start = sb.busy ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 3) != 0);
            r.op    = t_bus_op'($urandom_range(0, 1));
            r.addr  = pick_addr();
            r.wdata = pick_word();
            r.sdata = 1'($urandom_range(0, 1));
            r.lock  = 1'($urandom_range(0, 1));
            send_request(r);
        end
        // let any open frame run out so the registers can be touched
        while (!may_end_busy && sb.busy) begin
            r       = '0;
            r.sdata = 1'($urandom_range(0, 1));
            r.lock  = 1'($urandom_range(0, 1));
            send_request(r);
        end
    endtask

    // Register write once every result is back and the block has settled.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] value);
        s_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    initial begin
        t_bus_request r;
        int unsigned  phase_half[3];
        bit           phase_shdn[3];
        int           phase_items[3];

        phase_half  = '{3, 1, 65535};
        phase_shdn  = '{0, 1, 0};
        phase_items = '{150, 150, 100};
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle pins at reset settings, lock detect toggling
        for (int i = 0; i < 3; i++) begin
            r       = '0;
            r.lock  = 1'(i);
            r.sdata = 1'b1;
            send_request(r);
        end
        // all-ones write at the reset half-period
        run_frame(OP_WRITE, '1, '1, LINE_RANDOM, 1'b0);

        // fastest bus: extremes of address, data and the read line
        set_reg(CFG_HALF_PERIOD, 16'd1);
        run_frame(OP_WRITE, '0, '0, LINE_HIGH, 1'b0);
        run_frame(OP_READ, '1, '1, LINE_HIGH, 1'b0);
        run_frame(OP_READ, '0, '1, LINE_LOW, 1'b0);
        run_frame(OP_READ, 12'h5A5, $urandom, LINE_RANDOM, 1'b1);
        run_frame(OP_WRITE, 12'hA5A, 32'h5A5A_A5A5, LINE_RANDOM, 1'b1);

        // zero half-period behaves as one; shutdown pin asserted
        set_reg(CFG_SHUTDOWN, 16'd1);
        set_reg(CFG_HALF_PERIOD, 16'd0);
        run_frame(OP_READ, pick_addr(), $urandom, LINE_RANDOM, 1'b0);
        run_frame(OP_WRITE, pick_addr(), $urandom, LINE_RANDOM, 1'b0);

        // random phases; the slowest divider comes last and is left mid-frame
        for (int p = 0; p < 3; p++) begin
            if (p == 2) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            set_reg(CFG_HALF_PERIOD, HALF_W'(phase_half[p]));
            set_reg(CFG_SHUTDOWN, HALF_W'(phase_shdn[p]));
            run_random(phase_items[p], p == 2);
        end

        s_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.failures == 0 && sb.expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
